@@ hdl/hwt_pkg.sv @@
// Shared types, constants and helper functions of the handle table.
`default_nettype none

package hwt_pkg;

	// Table geometry.
	localparam int ENTRIES = 64;
	localparam int SLOT_W  = $clog2(ENTRIES);

	// Request queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Mode codes on the request port.
	localparam logic [2:0] MODE_CREATE  = 3'd0;
	localparam logic [2:0] MODE_LOOKUP  = 3'd1;
	localparam logic [2:0] MODE_CLOSE   = 3'd2;
	localparam logic [2:0] MODE_DISOWN  = 3'd3;
	localparam logic [2:0] MODE_CLEAR   = 3'd4;

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [ENTRIES-1:0] slot_mask_t;

	typedef enum logic [2:0] {
		OP_CREATE,
		OP_LOOKUP,
		OP_CLOSE,
		OP_DISOWN,
		OP_CLEAR,
		OP_BAD
	} hwt_op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_CLR,
		BK_CLR_EMIT
	} hwt_bstate_t;

	// A request after the front has classified it.
	typedef struct packed {
		hwt_op_t     op;
		logic        in_range;
		slot_t       slot;
		logic [7:0]  kind;
		logic [31:0] rights;
		logic [63:0] object_tag;
		logic        owns;
		logic [31:0] required_rights;
	} hwt_req_t;

	// Payload kept in the table memory for each slot.
	typedef struct packed {
		logic [7:0]  kind;
		logic [31:0] rights;
		logic [63:0] object_tag;
	} hwt_entry_t;

	// One result as it leaves the back.
	typedef struct packed {
		logic        ok;
		logic [5:0]  handle_out;
		logic [7:0]  kind_out;
		logic [31:0] rights_out;
		logic [63:0] object_out;
		logic        release_valid;
		logic [7:0]  release_kind;
		logic [63:0] release_object;
		logic        free_slot_available;
		logic        last;
	} hwt_res_t;

	// Priority encoder: index of the lowest set bit, zero when none is set.
	function automatic slot_t first_set(slot_mask_t v);
		slot_t idx;
		idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = slot_t'(i);
			end
		end
		return idx;
	endfunction

	// Mask of all slots at or above s.
	function automatic slot_mask_t at_or_above(slot_t s);
		return ~((slot_mask_t'(1) << s) - slot_mask_t'(1));
	endfunction

endpackage

`default_nettype wire

@@ hdl/hwt_front.sv @@
// Front end: takes requests from the port and classifies them for the queue.
`default_nettype none

module hwt_front (
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [2:0]        mode,
	input  wire logic [15:0]       handle,
	input  wire logic [7:0]        kind,
	input  wire logic [31:0]       rights,
	input  wire logic [63:0]       object_tag,
	input  wire logic              owns,
	input  wire logic [31:0]       required_rights,
	input  wire logic              queue_full,
	output logic                   push,
	output hwt_pkg::hwt_req_t      req
);

	hwt_pkg::hwt_op_t op;

	always_comb begin
		case (mode)
			hwt_pkg::MODE_CREATE: op = hwt_pkg::OP_CREATE;
			hwt_pkg::MODE_LOOKUP: op = hwt_pkg::OP_LOOKUP;
			hwt_pkg::MODE_CLOSE:  op = hwt_pkg::OP_CLOSE;
			hwt_pkg::MODE_DISOWN: op = hwt_pkg::OP_DISOWN;
			hwt_pkg::MODE_CLEAR:  op = hwt_pkg::OP_CLEAR;
			default:              op = hwt_pkg::OP_BAD;
		endcase
	end

	always_comb begin
		req.op              = op;
		req.in_range        = (handle < 16'(hwt_pkg::ENTRIES));
		req.slot            = handle[hwt_pkg::SLOT_W-1:0];
		req.kind            = kind;
		req.rights          = rights;
		req.object_tag      = object_tag;
		req.owns            = owns;
		req.required_rights = required_rights;
	end

	assign req_stall = queue_full;
	assign push      = req_valid && !queue_full;

endmodule

`default_nettype wire

@@ hdl/hwt_queue.sv @@
// Short request queue that decouples the front from the back.
`default_nettype none

module hwt_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire hwt_pkg::hwt_req_t  push_data,
	output logic                    full,
	input  wire logic               pop,
	output logic                    head_valid,
	output hwt_pkg::hwt_req_t       head
);

	hwt_pkg::hwt_req_t                slots_q [hwt_pkg::QUEUE_DEPTH];
	logic [hwt_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [hwt_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [hwt_pkg::QPTR_W:0]         count_q;

	assign full       = (count_q == (hwt_pkg::QPTR_W + 1)'(hwt_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == hwt_pkg::QPTR_W'(hwt_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == hwt_pkg::QPTR_W'(hwt_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ hdl/hwt_back.sv @@
// Back end: the handle table itself, its next-fit allocator and the result register.
`default_nettype none

module hwt_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write_en,
	input  wire logic               cfg_write_data,
	input  wire logic               head_valid,
	input  wire hwt_pkg::hwt_req_t  head,
	output logic                    pop,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output hwt_pkg::hwt_res_t       res
);

	hwt_pkg::hwt_bstate_t state_q, state_d;
	hwt_pkg::slot_mask_t  valid_q, valid_d;
	hwt_pkg::slot_mask_t  owns_q, owns_d;
	hwt_pkg::slot_mask_t  rel_q, rel_d;
	hwt_pkg::slot_t       hint_q, hint_d;
	logic                 clr_last_q, clr_last_d;
	logic                 rel_en_q;

	// Table payload memory: one write port, one registered read port.
	hwt_pkg::hwt_entry_t  mem [hwt_pkg::ENTRIES];
	hwt_pkg::hwt_entry_t  rd_q;
	logic                 mem_we, mem_re;
	hwt_pkg::slot_t       mem_waddr, mem_raddr;
	hwt_pkg::hwt_entry_t  mem_wdata;

	logic                 res_valid_q;
	hwt_pkg::hwt_res_t    res_q, res_d;
	logic                 load;

	hwt_pkg::slot_mask_t  free_mask, upper_free, rel_snap, rel_rest;
	hwt_pkg::slot_t       new_slot, rel_slot;
	logic                 any_free, free_after_create, hit, out_free;

	assign free_mask  = ~valid_q;
	assign any_free   = |free_mask;
	assign upper_free = free_mask & hwt_pkg::at_or_above(hint_q);
	assign new_slot   = (|upper_free) ? hwt_pkg::first_set(upper_free) :
		hwt_pkg::first_set(free_mask);
	assign free_after_create =
		|(free_mask & ~(hwt_pkg::slot_mask_t'(1) << new_slot));
	assign hit        = head.in_range && valid_q[head.slot];
	assign out_free   = !res_valid_q || !res_stall;
	assign rel_snap   = valid_q & owns_q & {hwt_pkg::ENTRIES{rel_en_q}};
	assign rel_slot   = hwt_pkg::first_set(rel_q);
	assign rel_rest   = rel_q & ~(hwt_pkg::slot_mask_t'(1) << rel_slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hwt_pkg::BK_IDLE;
			valid_q     <= '0;
			owns_q      <= '0;
			rel_q       <= '0;
			hint_q      <= '0;
			clr_last_q  <= 1'b0;
			rel_en_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			valid_q    <= valid_d;
			owns_q     <= owns_d;
			rel_q      <= rel_d;
			hint_q     <= hint_d;
			clr_last_q <= clr_last_d;
			if (cfg_write_en) begin
				rel_en_q <= cfg_write_data;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		valid_d    = valid_q;
		owns_d     = owns_q;
		rel_d      = rel_q;
		hint_d     = hint_q;
		clr_last_d = clr_last_q;
		pop        = 1'b0;
		load       = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = new_slot;
		mem_wdata  = '{kind: head.kind, rights: head.rights, object_tag: head.object_tag};
		mem_re     = 1'b0;
		mem_raddr  = head.slot;
		res_d      = '0;
		res_d.last = 1'b1;
		res_d.free_slot_available = any_free;

		case (state_q)
			hwt_pkg::BK_IDLE: begin
				if (head_valid && out_free) begin
					case (head.op)
						hwt_pkg::OP_CREATE: begin
							load = 1'b1;
							pop  = 1'b1;
							if (any_free) begin
								mem_we             = 1'b1;
								valid_d[new_slot]  = 1'b1;
								owns_d[new_slot]   = head.owns;
								hint_d = (new_slot == hwt_pkg::slot_t'(hwt_pkg::ENTRIES - 1)) ?
									'0 : new_slot + 1'b1;
								res_d.ok           = 1'b1;
								res_d.handle_out   = 6'(new_slot);
								res_d.free_slot_available = free_after_create;
							end
						end
						hwt_pkg::OP_LOOKUP, hwt_pkg::OP_CLOSE: begin
							if (hit) begin
								mem_re  = 1'b1;
								state_d = hwt_pkg::BK_READ;
							end else begin
								load = 1'b1;
								pop  = 1'b1;
							end
						end
						hwt_pkg::OP_DISOWN: begin
							load = 1'b1;
							pop  = 1'b1;
							if (hit) begin
								owns_d[head.slot] = 1'b0;
								res_d.ok          = 1'b1;
							end
						end
						hwt_pkg::OP_CLEAR: begin
							valid_d = '0;
							owns_d  = '0;
							hint_d  = '0;
							rel_d   = rel_snap;
							if (rel_snap == '0) begin
								load     = 1'b1;
								pop      = 1'b1;
								res_d.ok = 1'b1;
								res_d.free_slot_available = 1'b1;
							end else begin
								state_d = hwt_pkg::BK_CLR;
							end
						end
						default: begin
							load = 1'b1;
							pop  = 1'b1;
						end
					endcase
				end
			end
			hwt_pkg::BK_READ: begin
				load    = 1'b1;
				pop     = 1'b1;
				state_d = hwt_pkg::BK_IDLE;
				if (head.op == hwt_pkg::OP_LOOKUP) begin
					if ((rd_q.rights & head.required_rights) == head.required_rights) begin
						res_d.ok         = 1'b1;
						res_d.kind_out   = rd_q.kind;
						res_d.rights_out = rd_q.rights;
						res_d.object_out = rd_q.object_tag;
					end
				end else begin
					valid_d[head.slot] = 1'b0;
					owns_d[head.slot]  = 1'b0;
					res_d.ok           = 1'b1;
					res_d.free_slot_available = 1'b1;
					if (owns_q[head.slot] && rel_en_q) begin
						res_d.release_valid  = 1'b1;
						res_d.release_kind   = rd_q.kind;
						res_d.release_object = rd_q.object_tag;
					end
				end
			end
			hwt_pkg::BK_CLR: begin
				if (out_free) begin
					mem_re     = 1'b1;
					mem_raddr  = rel_slot;
					rel_d      = rel_rest;
					clr_last_d = (rel_rest == '0);
					state_d    = hwt_pkg::BK_CLR_EMIT;
				end
			end
			hwt_pkg::BK_CLR_EMIT: begin
				load                 = 1'b1;
				res_d.ok             = 1'b1;
				res_d.release_valid  = 1'b1;
				res_d.release_kind   = rd_q.kind;
				res_d.release_object = rd_q.object_tag;
				res_d.free_slot_available = 1'b1;
				res_d.last           = clr_last_q;
				if (clr_last_q) begin
					pop     = 1'b1;
					state_d = hwt_pkg::BK_IDLE;
				end else begin
					state_d = hwt_pkg::BK_CLR;
				end
			end
			default: begin
				state_d = hwt_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// The result register is empty whenever the back is about to fill it from a read.
	a_emit_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hwt_pkg::BK_READ || state_q == hwt_pkg::BK_CLR_EMIT) |-> !res_valid_q)
		else $error("result register busy when a table read completes");

	// No release work is left over once the back is idle.
	a_rel_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hwt_pkg::BK_IDLE) |-> (rel_q == '0))
		else $error("pending release mask not empty in idle");

	// While a clear is being drained the table holds no live entry.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hwt_pkg::BK_CLR || state_q == hwt_pkg::BK_CLR_EMIT) |-> (valid_q == '0))
		else $error("live entry during clear drain");

	// A request is only retired from the queue when one is present.
	a_pop_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	// An owned slot is always a live slot.
	a_owns_valid: assert property (@(posedge clk) disable iff (!arst_n)
		((owns_q & ~valid_q) == '0))
		else $error("owns flag set on a free slot");

endmodule

`default_nettype wire

@@ hdl/handle_table_with_rights.sv @@
// Top level of the handle table: request port, queue, table back end and result port.
`default_nettype none

// Handle table with rights: a table of 64 handle slots, each with a kind, a
// rights mask, a 64-bit object tag and an owns flag. A request carries a mode
// (create, lookup, close, disown, clear_all); every request gives one result,
// except clear_all, which gives one result per released object in ascending
// slot order (or a single result when nothing is released), the final one
// marked by last. Create picks the first free slot at or after a rotating
// hint. Both channels use valid and stall; a request is taken when req_valid
// is high and req_stall is low, a result is taken when res_valid is high and
// res_stall is low. A two-deep queue sits between the classifying front and
// the back end, so new requests are taken while a result waits at the output.
// In the back end, create, disown, unused modes and any lookup or close that
// misses its slot complete straight from idle; a lookup or close that finds a
// live slot passes through a read state, whether or not the rights check
// passes, because the slot payload lives in a RAM with one write and one
// registered read port; clear_all reads and emits each released object in
// turn. The back holds in place while a result sits stalled at the output.
// Slot valid and owns marks live in flip-flops cleared by reset, so there is
// no clearing pass after reset. release_enabled is written through
// cfg_write_en and cfg_write_data and should only change while the block is
// idle.
module handle_table_with_rights (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic        cfg_write_data,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [2:0]  mode,
	input  wire logic [15:0] handle,
	input  wire logic [7:0]  kind,
	input  wire logic [31:0] rights,
	input  wire logic [63:0] object_tag,
	input  wire logic        owns,
	input  wire logic [31:0] required_rights,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             ok,
	output logic [5:0]       handle_out,
	output logic [7:0]       kind_out,
	output logic [31:0]      rights_out,
	output logic [63:0]      object_out,
	output logic             release_valid,
	output logic [7:0]       release_kind,
	output logic [63:0]      release_object,
	output logic             free_slot_available,
	output logic             last
);

	hwt_pkg::hwt_req_t front_req;
	hwt_pkg::hwt_req_t head;
	hwt_pkg::hwt_res_t res;
	logic              push;
	logic              queue_full;
	logic              head_valid;
	logic              pop;

	// The front classifies each request and pushes it into the queue.
	hwt_front u_front (
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.mode            (mode),
		.handle          (handle),
		.kind            (kind),
		.rights          (rights),
		.object_tag      (object_tag),
		.owns            (owns),
		.required_rights (required_rights),
		.queue_full      (queue_full),
		.push            (push),
		.req             (front_req)
	);

	hwt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (front_req),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// The back owns all table state and the result register.
	hwt_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.res            (res)
	);

	assign ok                  = res.ok;
	assign handle_out          = res.handle_out;
	assign kind_out            = res.kind_out;
	assign rights_out          = res.rights_out;
	assign object_out          = res.object_out;
	assign release_valid       = res.release_valid;
	assign release_kind        = res.release_kind;
	assign release_object      = res.release_object;
	assign free_slot_available = res.free_slot_available;
	assign last                = res.last;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for the handle table with rights.
`timescale 1ns / 100ps

// The bench drives requests into the handle table over the valid/stall request
// channel and takes results off the valid/stall result channel. A predictor
// inside the bench keeps its own copy of the slot table, the create hint and
// the release setting. For every accepted request it queues the results the
// table must give. The result checker compares each accepted result with the
// oldest queued expectation, field by field.
//
// The run is built in phases:
//   - a directed table of requests: empty table, out-of-range handles, unused
//     modes, extreme field values, missing rights, disown, close with and
//     without a release, and clear_all with and without releases;
//   - random traffic, mostly built on live handles so that lookups, closes
//     and disowns reach real entries, plus some noise requests;
//   - a pressure phase in which the receiver holds off for a long stretch while
//     the sender keeps offering creates, so the table fills and the request
//     side stalls, followed by a full clear with one release per slot.
// The release setting is only changed while the table is idle, that is, once
// every expected result has come back.
module tb;

	// Mode codes that the table does not implement.
	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int LONG_HOLD    = 400;
	localparam int END_CYCLES   = 2 * hwt_pkg::ENTRIES + 16;

	// One request as the sender offers it.
	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] handle;
		logic [7:0]  kind;
		logic [31:0] rights;
		logic [63:0] object_tag;
		logic        owns;
		logic [31:0] required_rights;
	} hreq_t;

	// One row of the directed table. Where typed is set, the expected ok and
	// handle are written into the row; every other field of such a result is
	// zero, free is set and last is set.
	typedef struct packed {
		hreq_t      req;
		logic       typed;
		logic       exp_ok;
		logic [5:0] exp_handle;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic        cfg_write_data = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [2:0]  mode = '0;
	logic [15:0] handle = '0;
	logic [7:0]  kind = '0;
	logic [31:0] rights = '0;
	logic [63:0] object_tag = '0;
	logic        owns = 1'b0;
	logic [31:0] required_rights = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        ok;
	logic [5:0]  handle_out;
	logic [7:0]  kind_out;
	logic [31:0] rights_out;
	logic [63:0] object_out;
	logic        release_valid;
	logic [7:0]  release_kind;
	logic [63:0] release_object;
	logic        free_slot_available;
	logic        last;

	// Predicted table state.
	bit        live [hwt_pkg::ENTRIES];
	bit [7:0]  slot_kind [hwt_pkg::ENTRIES];
	bit [31:0] slot_rights [hwt_pkg::ENTRIES];
	bit [63:0] slot_obj [hwt_pkg::ENTRIES];
	bit        slot_owns [hwt_pkg::ENTRIES];
	int        hint = 0;
	bit        rel_en = 1'b0;

	hwt_pkg::hwt_res_t expected_results [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_go = 1'b0;
	bit hold_started = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int releases_seen = 0;
	int mismatches = 0;
	int full_creates = 0;
	int max_clear_results = 0;

	always #2 clk = ~clk;

	handle_table_with_rights u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.mode(mode),
		.handle(handle),
		.kind(kind),
		.rights(rights),
		.object_tag(object_tag),
		.owns(owns),
		.required_rights(required_rights),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.ok(ok),
		.handle_out(handle_out),
		.kind_out(kind_out),
		.rights_out(rights_out),
		.object_out(object_out),
		.release_valid(release_valid),
		.release_kind(release_kind),
		.release_object(release_object),
		.free_slot_available(free_slot_available),
		.last(last)
	);

	function automatic bit any_slot_free();
		foreach (live[i]) begin
			if (!live[i]) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void clear_slot(int s);
		live[s] = 1'b0;
		slot_kind[s] = '0;
		slot_rights[s] = '0;
		slot_obj[s] = '0;
		slot_owns[s] = 1'b0;
	endfunction

	// Works out the results of one accepted request and updates the predicted
	// table. Every mode but clear_all gives exactly one result.
	task automatic predict_table_op(input hreq_t r);
		hwt_pkg::hwt_res_t res;
		int slot;
		int n_rel;
		bit found;
		res = '0;
		res.last = 1'b1;
		if (r.mode == hwt_pkg::MODE_CLEAR) begin
			// Releases go out in ascending slot order, then the table empties.
			n_rel = 0;
			foreach (live[i]) begin
				if (live[i] && slot_owns[i] && rel_en) n_rel++;
			end
			if (n_rel > max_clear_results) max_clear_results = n_rel;
			res.ok = 1'b1;
			res.free_slot_available = 1'b1;
			if (n_rel == 0) begin
				expected_results.push_back(res);
			end
			foreach (live[i]) begin
				if (live[i] && slot_owns[i] && rel_en) begin
					n_rel--;
					res.release_valid = 1'b1;
					res.release_kind = slot_kind[i];
					res.release_object = slot_obj[i];
					res.last = (n_rel == 0);
					expected_results.push_back(res);
				end
			end
			foreach (live[i]) clear_slot(i);
			hint = 0;
			return;
		end
		case (r.mode)
			hwt_pkg::MODE_CREATE: begin
				// Next fit: first free slot at or after the hint, wrapping.
				found = 1'b0;
				for (int i = 0; i < hwt_pkg::ENTRIES; i++) begin
					slot = (hint + i) % hwt_pkg::ENTRIES;
					if (!found && !live[slot]) begin
						found = 1'b1;
						live[slot] = 1'b1;
						slot_kind[slot] = r.kind;
						slot_rights[slot] = r.rights;
						slot_obj[slot] = r.object_tag;
						slot_owns[slot] = r.owns;
						hint = (slot + 1) % hwt_pkg::ENTRIES;
						res.ok = 1'b1;
						res.handle_out = 6'(slot);
					end
				end
				if (!found) full_creates++;
			end
			hwt_pkg::MODE_LOOKUP, hwt_pkg::MODE_CLOSE, hwt_pkg::MODE_DISOWN: begin
				if (r.handle < hwt_pkg::ENTRIES && live[int'(r.handle)]) begin
					slot = int'(r.handle);
					if (r.mode == hwt_pkg::MODE_LOOKUP) begin
						if ((slot_rights[slot] & r.required_rights) == r.required_rights) begin
							res.ok = 1'b1;
							res.kind_out = slot_kind[slot];
							res.rights_out = slot_rights[slot];
							res.object_out = slot_obj[slot];
						end
					end else if (r.mode == hwt_pkg::MODE_CLOSE) begin
						res.ok = 1'b1;
						if (slot_owns[slot] && rel_en) begin
							res.release_valid = 1'b1;
							res.release_kind = slot_kind[slot];
							res.release_object = slot_obj[slot];
						end
						clear_slot(slot);
					end else begin
						res.ok = 1'b1;
						slot_owns[slot] = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		res.free_slot_available = any_slot_free();
		expected_results.push_back(res);
	endtask

	function automatic int pick_live_slot();
		int n_live;
		int k;
		n_live = 0;
		foreach (live[i]) begin
			if (live[i]) n_live++;
		end
		if (n_live == 0) return -1;
		k = $urandom_range(n_live - 1);
		foreach (live[i]) begin
			if (live[i]) begin
				if (k == 0) return i;
				k--;
			end
		end
		return -1;
	endfunction

	// Random request. Most requests are well formed and aim at live handles;
	// the rest is noise over every mode code and the whole handle range.
	function automatic hreq_t random_request();
		hreq_t r;
		int pick;
		int s;
		r.mode = hwt_pkg::MODE_CREATE;
		r.handle = 16'($urandom);
		r.kind = 8'($urandom);
		r.rights = $urandom;
		r.object_tag = {$urandom, $urandom};
		r.owns = 1'($urandom);
		r.required_rights = $urandom;
		pick = $urandom_range(99);
		s = pick_live_slot();
		if (pick < 35) begin
			r.mode = hwt_pkg::MODE_CREATE;
		end else if (pick < 88) begin
			if (pick < 60) r.mode = hwt_pkg::MODE_LOOKUP;
			else if (pick < 75) r.mode = hwt_pkg::MODE_CLOSE;
			else if (pick < 85) r.mode = hwt_pkg::MODE_DISOWN;
			else r.mode = hwt_pkg::MODE_CLEAR;
			if (s >= 0) r.handle = 16'(s);
			else r.handle = 16'($urandom_range(hwt_pkg::ENTRIES - 1));
			// Mostly ask for rights the entry holds, so lookups can pass.
			if (s >= 0 && $urandom_range(3) != 0) r.required_rights = slot_rights[s] & $urandom;
		end else begin
			r.mode = 3'($urandom);
			if ($urandom_range(1) == 0) r.handle = 16'($urandom_range(hwt_pkg::ENTRIES - 1));
		end
		return r;
	endfunction

	function automatic dir_row_t make_row(logic [2:0] m, logic [15:0] h, logic [7:0] k,
			logic [31:0] rt, logic [63:0] obj, logic ow, logic [31:0] rq,
			logic typed, logic eok, logic [5:0] eh);
		dir_row_t row;
		row.req = '{m, h, k, rt, obj, ow, rq};
		row.typed = typed;
		row.exp_ok = eok;
		row.exp_handle = eh;
		return row;
	endfunction

	// Offers one request and waits for the edge that accepts it. An idle gap
	// of random length may come first. The task returns at the accepting edge,
	// so a following request keeps valid high without a dip.
	task automatic offer_request(input hreq_t r, input bit typed,
			input hwt_pkg::hwt_res_t typed_res);
		if ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		req_valid <= 1'b1;
		mode <= r.mode;
		handle <= r.handle;
		kind <= r.kind;
		rights <= r.rights;
		object_tag <= r.object_tag;
		owns <= r.owns;
		required_rights <= r.required_rights;
		@(posedge clk);
		while (req_stall !== 1'b0) @(posedge clk);
		requests_sent++;
		predict_table_op(r);
		// A typed row replaces the single predicted result with its own.
		if (typed) begin
			void'(expected_results.pop_back());
			expected_results.push_back(typed_res);
		end
	endtask

	// Stops offering and waits until every expected result has come back.
	// Returns at a rising edge.
	task automatic wait_results_drained();
		req_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Writes the release setting; the table must be idle.
	task automatic write_release_enable(input bit v);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		rel_en = v;
	endtask

	task automatic run_random_phase(input int n_items, input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (n_items) offer_request(random_request(), 1'b0, '0);
	endtask

	task automatic show_result(input string tag, input hwt_pkg::hwt_res_t r);
		$display("  %s ok=%b h=%0d kind=%h rights=%h obj=%h rel=%b rk=%h ro=%h free=%b last=%b",
			tag, r.ok, r.handle_out, r.kind_out, r.rights_out, r.object_out,
			r.release_valid, r.release_kind, r.release_object, r.free_slot_available,
			r.last);
	endtask

	// Receiver stall. A long hold-off, when running, overrides the random one.
	always @(posedge clk) begin
		res_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct);
	end

	// Counts down the long receiver hold-off, cycle by cycle. It is loaded once,
	// when the main sequence asks for it.
	always @(posedge clk) begin
		if (hold_go && !hold_started) begin
			hold_left <= LONG_HOLD;
			hold_started <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result checker: every accepted result must match the oldest expectation.
	always @(posedge clk) begin : result_check
		hwt_pkg::hwt_res_t got;
		hwt_pkg::hwt_res_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			got = {ok, handle_out, kind_out, rights_out, object_out, release_valid,
				release_kind, release_object, free_slot_available, last};
			results_seen++;
			if (got.release_valid) releases_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result arrived with nothing pending", $realtime);
					show_result("actual  ", got);
				end
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result mismatch", $realtime);
						show_result("expected", want);
						show_result("actual  ", got);
					end
				end
			end
		end
	end

	// Guard against a hang anywhere in the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results still pending", cycle_count,
				expected_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : main_seq
		dir_row_t dir_tab [$];
		hwt_pkg::hwt_res_t typed_res;
		hreq_t fill_req;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, releases enabled. The table never gets full here, so
		// every typed row expects free to be set.
		write_release_enable(1'b1);
		// Empty table after reset: nothing to look up, close or disown.
		dir_tab.push_back(make_row(hwt_pkg::MODE_LOOKUP, 16'd0, 8'h00, 32'h0, 64'h0,
			1'b0, 32'h0, 1'b1, 1'b0, 6'd0));
		dir_tab.push_back(make_row(hwt_pkg::MODE_CLOSE, 16'd0, 8'h00, 32'h0, 64'h0,
			1'b0, 32'h0, 1'b1, 1'b0, 6'd0));
		// Out-of-range handles: the largest and the first one past the table.
		dir_tab.push_back(make_row(hwt_pkg::MODE_DISOWN, 16'hFFFF, 8'h00, 32'h0, 64'h0,
			1'b0, 32'h0, 1'b1, 1'b0, 6'd0));
		dir_tab.push_back(make_row(hwt_pkg::MODE_LOOKUP, 16'd64, 8'h00, 32'h0, 64'h0,
			1'b0, 32'h0, 1'b1, 1'b0, 6'd0));
		// Unused mode codes fail without touching the table.
		dir_tab.push_back(make_row(MODE_UNUSED_LO, 16'd0, 8'h00, 32'h0, 64'h0, 1'b0, 32'h0,
			1'b1, 1'b0, 6'd0));
		dir_tab.push_back(make_row(MODE_UNUSED_HI, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 6'd0));
		// Creates fill slots 0, 1 and 2 with all-ones, all-zeros and a mixed entry.
		dir_tab.push_back(make_row(hwt_pkg::MODE_CREATE, 16'd0, 8'hFF, 32'hFFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h0, 1'b1, 1'b1, 6'd0));
		dir_tab.push_back(make_row(hwt_pkg::MODE_CREATE, 16'hFFFF, 8'h00, 32'h0, 64'h0,
			1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 6'd1));
		dir_tab.push_back(make_row(hwt_pkg::MODE_CREATE, 16'd0, 8'h5A, 32'h0000_F0F0,
			64'h0123_4567_89AB_CDEF, 1'b1, 32'h0, 1'b1, 1'b1, 6'd2));
		// Lookups: all rights held, a missing right, a subset, no rights asked, and a right asked of an empty mask.
		dir_tab.push_back(make_row(hwt_pkg::MODE_LOOKUP, 16'd0, 8'h00, 32'h0, 64'h0,
			1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 6'd0));
		dir_tab.push_back(make_row(hwt_pkg::MODE_LOOKUP, 16'd2, 8'h00, 32'h0, 64'h0,
			1'b0, 32'h0001_0000, 1'b1, 1'b0, 6'd0));
		dir_tab.push_back(make_row(hwt_pkg::MODE_LOOKUP, 16'd2, 8'h00, 32'h0, 64'h0,
			1'b0, 32'h0000_F000, 1'b0, 1'b0, 6'd0));
		dir_tab.push_back(make_row(hwt_pkg::MODE_LOOKUP, 16'd1, 8'h00, 32'h0, 64'h0,
			1'b0, 32'h0, 1'b0, 1'b0, 6'd0));
		dir_tab.push_back(make_row(hwt_pkg::MODE_LOOKUP, 16'd1, 8'h00, 32'h0, 64'h0,
			1'b0, 32'h1, 1'b1, 1'b0, 6'd0));
		// Disown, then close gives no release; the slot is gone afterwards.
		dir_tab.push_back(make_row(hwt_pkg::MODE_DISOWN, 16'd2, 8'h00, 32'h0, 64'h0,
			1'b0, 32'h0, 1'b1, 1'b1, 6'd0));
		dir_tab.push_back(make_row(hwt_pkg::MODE_CLOSE, 16'd2, 8'h00, 32'h0, 64'h0,
			1'b0, 32'h0, 1'b1, 1'b1, 6'd0));
		dir_tab.push_back(make_row(hwt_pkg::MODE_LOOKUP, 16'd2, 8'h00, 32'h0, 64'h0,
			1'b0, 32'h0, 1'b1, 1'b0, 6'd0));
		// Closing an owned slot releases its object; a second close fails.
		dir_tab.push_back(make_row(hwt_pkg::MODE_CLOSE, 16'd0, 8'h00, 32'h0, 64'h0,
			1'b0, 32'h0, 1'b0, 1'b0, 6'd0));
		dir_tab.push_back(make_row(hwt_pkg::MODE_CLOSE, 16'd0, 8'h00, 32'h0, 64'h0,
			1'b0, 32'h0, 1'b1, 1'b0, 6'd0));
		// The hint sits after slot 2, so the freed slot 0 is skipped.
		dir_tab.push_back(make_row(hwt_pkg::MODE_CREATE, 16'd0, 8'h3C, 32'hAAAA_5555,
			64'hFEDC_BA98_7654_3210, 1'b1, 32'h0, 1'b1, 1'b1, 6'd3));
		// Clear with one owned entry, then clear of an empty table.
		dir_tab.push_back(make_row(hwt_pkg::MODE_CLEAR, 16'd0, 8'h00, 32'h0, 64'h0,
			1'b0, 32'h0, 1'b0, 1'b0, 6'd0));
		dir_tab.push_back(make_row(hwt_pkg::MODE_CLEAR, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 6'd0));
		// The hint is back at slot 0 after a clear.
		dir_tab.push_back(make_row(hwt_pkg::MODE_CREATE, 16'd0, 8'h81, 32'h8000_0001,
			64'h8000_0000_0000_0001, 1'b0, 32'h0, 1'b1, 1'b1, 6'd0));

		foreach (dir_tab[i]) begin
			typed_res = '0;
			typed_res.ok = dir_tab[i].exp_ok;
			typed_res.handle_out = dir_tab[i].exp_handle;
			typed_res.free_slot_available = 1'b1;
			typed_res.last = 1'b1;
			offer_request(dir_tab[i].req, dir_tab[i].typed, typed_res);
		end
		wait_results_drained();

		// Sender idles lightly, receiver heavily; owned objects are not released.
		write_release_enable(1'b0);
		run_random_phase(90, 15, 67);
		wait_results_drained();

		// Pressure: the receiver holds off while the sender keeps offering. A clear
		// empties the table, then owned creates fill every slot and run past the
		// end into creates on a full table.
		write_release_enable(1'b1);
		tx_idle_pct = 0;
		rx_idle_pct = 15;
		hold_go <= 1'b1;
		fill_req = random_request();
		fill_req.mode = hwt_pkg::MODE_CLEAR;
		offer_request(fill_req, 1'b0, '0);
		repeat (hwt_pkg::ENTRIES + 6) begin
			fill_req = random_request();
			fill_req.mode = hwt_pkg::MODE_CREATE;
			fill_req.owns = 1'b1;
			offer_request(fill_req, 1'b0, '0);
		end
		// Pause until every result is back, then release the whole table at once.
		wait_results_drained();
		fill_req.mode = hwt_pkg::MODE_CLEAR;
		offer_request(fill_req, 1'b0, '0);
		wait_results_drained();

		// Sender idles heavily, receiver lightly; releases stay enabled.
		run_random_phase(85, 67, 15);
		wait_results_drained();

		// No idling on either side, releases disabled again.
		write_release_enable(1'b0);
		run_random_phase(80, 0, 0);
		wait_results_drained();

		// Anything arriving now is a result that nothing asked for.
		repeat (END_CYCLES) @(posedge clk);

		$display("Sent %0d requests, checked %0d results with %0d releases, %0d mismatches.",
			requests_sent, results_seen, releases_seen, mismatches);
		$display("Creates on a full table: %0d; largest release burst from one clear: %0d.",
			full_creates, max_clear_results);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/hwt_pkg.sv
hdl/hwt_front.sv
hdl/hwt_queue.sv
hdl/hwt_back.sv
hdl/handle_table_with_rights.sv
bench/tb.sv
